// ===== src/scf_pkg.sv =====
// Package for the scroll camera follow unit: payload types, opcodes, register indexes, helpers.
`default_nettype none
package scf_pkg;

   localparam int unsigned FRAC_BITS = 8;
   localparam logic [7:0] SHIFT_LIMIT = 8'd7;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      OP_SET     = 3'd0,
      OP_ADD     = 3'd1,
      OP_TARGET  = 3'd2,
      OP_UNTRACK = 3'd3,
      OP_STEP    = 3'd4,
      OP_RECLAMP = 3'd5,
      OP_TO_SCR  = 3'd6,
      OP_TO_WLD  = 3'd7
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_X  = 3'd0,
      CSR_MIN_Y  = 3'd1,
      CSR_MAX_X  = 3'd2,
      CSR_MAX_Y  = 3'd3,
      CSR_ENABLE = 3'd4
   } csr_addr_type;

   typedef struct packed {
      logic [2:0]          opcode;
      logic signed [15:0]  value_x;
      logic signed [15:0]  value_y;
      logic [7:0]          step_shift;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic [7:0]          scroll_x;
      logic [7:0]          scroll_y;
      logic signed [15:0]  conv_x;
      logic signed [15:0]  conv_y;
      logic                following;
   } rsp_type;

   // When the bounds cross, a value below the minimum takes the minimum and any other value takes the maximum.
   function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
      logic signed [15:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Integer part of a Q8.8 value, sign extended to 16 bits.
   function automatic logic signed [15:0] int_part(input logic signed [15:0] v);
      return v >>> FRAC_BITS;
   endfunction

endpackage
`default_nettype wire

// ===== src/scroll_camera_follow_unit.sv =====
// Scroll camera follow unit: Q8.8 camera position, target following, clamping, conversions.
//
// Usage:
//  - Request channel (req_valid, req_stall, req_data): one command per request,
//    taken at an edge where req_valid is high and req_stall is low.
//  - Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response per
//    request, in order, held stable while rsp_stall is high.
//  - CSR port (csr_wen, csr_addr, csr_wdata): bounds and clamp enable; write only
//    while no request is in flight.
//  - Path from request accept to response valid: the request register, then the update
//    logic writes the camera state and the response register.
//  - Throughput: one request per cycle while the response is not stalled; the camera
//    state is read and written once per cycle, when the single update stage advances.
//  - Stall: a stalled response holds the update stage; the request register still takes
//    one more request if it is empty, then req_stall rises until the response drains.
//  - Reset: clears position, target, following and all CSRs to zero and empties
//    both stages.
`default_nettype none
module scroll_camera_follow_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire scf_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output scf_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_wen,
   input  wire logic [scf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [scf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   scf_pkg::req_type     in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   scf_pkg::rsp_type     out_data_ff, out_data_in;

   logic signed [15:0]   cam_x_ff, cam_x_in, cam_y_ff, cam_y_in;
   logic signed [15:0]   goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic                 follow_ff, follow_in;

   logic signed [15:0]   min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic                 bound_en_ff;

   logic                 out_free, advance, take;
   scf_pkg::op_type      op;
   logic [2:0]           shift;
   logic signed [15:0]   dx, dy, stepped_x, stepped_y;
   logic signed [15:0]   pre_x, pre_y;
   logic                 do_clamp;
   logic signed [15:0]   conv_x, conv_y;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Update stage.
   always_comb begin
      op        = scf_pkg::op_type'(in_data_ff.opcode);
      shift     = (in_data_ff.step_shift > scf_pkg::SHIFT_LIMIT) ?
                  scf_pkg::SHIFT_LIMIT[2:0] : in_data_ff.step_shift[2:0];
      dx        = goal_x_ff - cam_x_ff;
      dy        = goal_y_ff - cam_y_ff;
      stepped_x = cam_x_ff + (dx >>> shift);
      stepped_y = cam_y_ff + (dy >>> shift);
      pre_x     = cam_x_ff;
      pre_y     = cam_y_ff;
      do_clamp  = 1'b0;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      follow_in = follow_ff;
      conv_x    = '0;
      conv_y    = '0;
      unique case (op)
         scf_pkg::OP_SET: begin
            pre_x    = in_data_ff.value_x;
            pre_y    = in_data_ff.value_y;
            do_clamp = 1'b1;
         end
         scf_pkg::OP_ADD: begin
            pre_x    = cam_x_ff + in_data_ff.value_x;
            pre_y    = cam_y_ff + in_data_ff.value_y;
            do_clamp = 1'b1;
         end
         scf_pkg::OP_TARGET: begin
            goal_x_in = in_data_ff.value_x;
            goal_y_in = in_data_ff.value_y;
            follow_in = 1'b1;
         end
         scf_pkg::OP_UNTRACK: begin
            follow_in = 1'b0;
         end
         scf_pkg::OP_STEP: begin
            if (follow_ff) begin
               pre_x    = stepped_x;
               pre_y    = stepped_y;
               do_clamp = 1'b1;
               // drop following once the target is hit exactly, before clamping
               if (stepped_x == goal_x_ff && stepped_y == goal_y_ff) begin
                  follow_in = 1'b0;
               end
            end
         end
         scf_pkg::OP_RECLAMP: begin
            do_clamp = 1'b1;
         end
         scf_pkg::OP_TO_SCR: begin
            conv_x = in_data_ff.value_x - scf_pkg::int_part(cam_x_ff);
            conv_y = in_data_ff.value_y - scf_pkg::int_part(cam_y_ff);
         end
         scf_pkg::OP_TO_WLD: begin
            conv_x = in_data_ff.value_x + scf_pkg::int_part(cam_x_ff);
            conv_y = in_data_ff.value_y + scf_pkg::int_part(cam_y_ff);
         end
         default: begin
         end
      endcase
      if (do_clamp && bound_en_ff) begin
         cam_x_in = scf_pkg::clamp16(pre_x, min_x_ff, max_x_ff);
         cam_y_in = scf_pkg::clamp16(pre_y, min_y_ff, max_y_ff);
      end else begin
         cam_x_in = pre_x;
         cam_y_in = pre_y;
      end
      out_data_in.pos_x     = cam_x_in;
      out_data_in.pos_y     = cam_y_in;
      out_data_in.scroll_x  = cam_x_in[15:8];
      out_data_in.scroll_y  = cam_y_in[15:8];
      out_data_in.conv_x    = conv_x;
      out_data_in.conv_y    = conv_y;
      out_data_in.following = follow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         follow_ff    <= 1'b0;
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         bound_en_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cam_x_ff  <= cam_x_in;
            cam_y_ff  <= cam_y_in;
            goal_x_ff <= goal_x_in;
            goal_y_ff <= goal_y_in;
            follow_ff <= follow_in;
         end
         if (csr_wen) begin
            unique case (csr_addr)
               scf_pkg::CSR_MIN_X:  min_x_ff    <= csr_wdata;
               scf_pkg::CSR_MIN_Y:  min_y_ff    <= csr_wdata;
               scf_pkg::CSR_MAX_X:  max_x_ff    <= csr_wdata;
               scf_pkg::CSR_MAX_Y:  max_y_ff    <= csr_wdata;
               scf_pkg::CSR_ENABLE: bound_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTH
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stall without a held request");

   a_untrack_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (in_data_ff.opcode == scf_pkg::OP_UNTRACK) |=> !rsp_data.following)
      else $error("clear target left following on");

   a_conv_zero: assert property (@(posedge clock) disable iff (reset)
      advance && (in_data_ff.opcode != scf_pkg::OP_TO_SCR)
      && (in_data_ff.opcode != scf_pkg::OP_TO_WLD)
      |=> (rsp_data.conv_x == 16'sd0) && (rsp_data.conv_y == 16'sd0))
      else $error("conversion field nonzero on a non-conversion request");

   a_set_clamped: assert property (@(posedge clock) disable iff (reset)
      advance && (in_data_ff.opcode == scf_pkg::OP_SET) && bound_en_ff
      && (min_x_ff <= max_x_ff)
      |=> (rsp_data.pos_x >= $past(min_x_ff)) && (rsp_data.pos_x <= $past(max_x_ff)))
      else $error("set position escaped the horizontal bounds");

   a_state_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data.pos_x == cam_x_ff) && (rsp_data.following == follow_ff))
      else $error("response disagrees with camera state");
`endif

endmodule
`default_nettype wire

// ===== verif/scroll_camera_follow_unit_test.sv =====
// Self-checking testbench for the scroll camera follow unit.
`timescale 1ns / 1ps
module scroll_camera_follow_unit_test;

   localparam int CYCLE_LIMIT = 400000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   scf_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   scf_pkg::rsp_type               rsp_data;
   logic                           csr_wen = 1'b0;
   scf_pkg::csr_addr_type          csr_addr = scf_pkg::CSR_MIN_X;
   logic [scf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Camera shadow: position, target, follow flag and clamp settings.
   logic signed [15:0] view_x = '0;
   logic signed [15:0] view_y = '0;
   logic signed [15:0] aim_x = '0;
   logic signed [15:0] aim_y = '0;
   logic               chasing = 1'b0;
   logic signed [15:0] lim_lo_x = '0;
   logic signed [15:0] lim_lo_y = '0;
   logic signed [15:0] lim_hi_x = '0;
   logic signed [15:0] lim_hi_y = '0;
   logic               lim_on = 1'b0;

   scf_pkg::rsp_type views_due[$];
   int      errors = 0;
   int      burst_left = 0;
   int      stall_mode = 0;
   int      stall_span = 0;
   int      stall_run = 0;
   logic    stall_hold = 1'b0;

   scroll_camera_follow_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [15:0] bound_axis(input logic signed [15:0] v,
                                                    input logic signed [15:0] lo,
                                                    input logic signed [15:0] hi);
      if (!lim_on) return v;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the camera shadow by one command and return the view it produces.
   function automatic scf_pkg::rsp_type track_camera(input scf_pkg::req_type cmd);
      scf_pkg::rsp_type   view;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [2:0]         sh;
      view = '0;
      case (scf_pkg::op_type'(cmd.opcode))
         scf_pkg::OP_SET: begin
            view_x = bound_axis(cmd.value_x, lim_lo_x, lim_hi_x);
            view_y = bound_axis(cmd.value_y, lim_lo_y, lim_hi_y);
         end
         scf_pkg::OP_ADD: begin
            view_x = bound_axis(view_x + cmd.value_x, lim_lo_x, lim_hi_x);
            view_y = bound_axis(view_y + cmd.value_y, lim_lo_y, lim_hi_y);
         end
         scf_pkg::OP_TARGET: begin
            aim_x = cmd.value_x;
            aim_y = cmd.value_y;
            chasing = 1'b1;
         end
         scf_pkg::OP_UNTRACK: begin
            chasing = 1'b0;
         end
         scf_pkg::OP_STEP: begin
            if (chasing) begin
               sh = (cmd.step_shift > scf_pkg::SHIFT_LIMIT) ?
                    3'(scf_pkg::SHIFT_LIMIT) : cmd.step_shift[2:0];
               dx = aim_x - view_x;
               dy = aim_y - view_y;
               view_x = view_x + (dx >>> sh);
               view_y = view_y + (dy >>> sh);
               // arrival is judged before the clamp
               if (view_x == aim_x && view_y == aim_y) chasing = 1'b0;
               view_x = bound_axis(view_x, lim_lo_x, lim_hi_x);
               view_y = bound_axis(view_y, lim_lo_y, lim_hi_y);
            end
         end
         scf_pkg::OP_RECLAMP: begin
            view_x = bound_axis(view_x, lim_lo_x, lim_hi_x);
            view_y = bound_axis(view_y, lim_lo_y, lim_hi_y);
         end
         scf_pkg::OP_TO_SCR: begin
            view.conv_x = cmd.value_x - (view_x >>> scf_pkg::FRAC_BITS);
            view.conv_y = cmd.value_y - (view_y >>> scf_pkg::FRAC_BITS);
         end
         scf_pkg::OP_TO_WLD: begin
            view.conv_x = cmd.value_x + (view_x >>> scf_pkg::FRAC_BITS);
            view.conv_y = cmd.value_y + (view_y >>> scf_pkg::FRAC_BITS);
         end
      endcase
      view.pos_x = view_x;
      view.pos_y = view_y;
      view.scroll_x = view_x[15:8];
      view.scroll_y = view_y[15:8];
      view.following = chasing;
      return view;
   endfunction

   function automatic scf_pkg::req_type make_cmd(input scf_pkg::op_type op,
                                                 input logic [15:0] x,
                                                 input logic [15:0] y, input logic [7:0] sh);
      scf_pkg::req_type c;
      c.opcode = op;
      c.value_x = x;
      c.value_y = y;
      c.step_shift = sh;
      return c;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_offset();
      return 16'($urandom_range(0, 63)) - 16'd32;
   endfunction

   function automatic logic [7:0] pick_shift();
      return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
   endfunction

   // Send one request in bursts with random gaps, predict it once accepted.
   task automatic issue_command(input scf_pkg::req_type cmd);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_stall);
      views_due.push_back(track_camera(cmd));
   endtask

   task automatic settle_outputs();
      req_valid <= 1'b0;
      while (views_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic program_bounds(input logic signed [15:0] lo_x, input logic signed [15:0] lo_y,
                                 input logic signed [15:0] hi_x, input logic signed [15:0] hi_y,
                                 input logic on);
      settle_outputs();
      csr_wen <= 1'b1;
      csr_addr <= scf_pkg::CSR_MIN_X;
      csr_wdata <= lo_x;
      @(posedge clock);
      csr_addr <= scf_pkg::CSR_MIN_Y;
      csr_wdata <= lo_y;
      @(posedge clock);
      csr_addr <= scf_pkg::CSR_MAX_X;
      csr_wdata <= hi_x;
      @(posedge clock);
      csr_addr <= scf_pkg::CSR_MAX_Y;
      csr_wdata <= hi_y;
      @(posedge clock);
      // only bit 0 of the enable register counts
      csr_addr <= scf_pkg::CSR_ENABLE;
      csr_wdata <= {15'($urandom), on};
      @(posedge clock);
      csr_wen <= 1'b0;
      lim_lo_x = lo_x;
      lim_lo_y = lo_y;
      lim_hi_x = hi_x;
      lim_hi_y = hi_y;
      lim_on = on;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Wraparound, conversions and plain following with clamping off.
   task automatic test_wrap_and_convert();
      issue_command(make_cmd(scf_pkg::OP_RECLAMP, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_SET, 16'h7FFF, 16'h8000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TO_SCR, 16'h8000, 16'h7FFF, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TO_WLD, 16'h7FFF, 16'h8000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_ADD, 16'h0001, 16'hFFFF, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_SET, 16'h0180, 16'hFE80, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TO_SCR, 16'h0010, 16'h0010, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TARGET, 16'h1000, 16'hF000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'hFF));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'hFFFF, 16'hFFFF, 8'h03));
      issue_command(make_cmd(scf_pkg::OP_UNTRACK, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TARGET, 16'h1000, 16'h1000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h00));
   endtask

   // Crossed bounds on x, full range on y; a step that lands outside is clamped after arrival.
   task automatic test_bound_corners();
      program_bounds(16'sh0100, 16'sh8000, 16'shFF00, 16'sh7FFF, 1'b1);
      issue_command(make_cmd(scf_pkg::OP_SET, 16'h0000, 16'h1234, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_SET, 16'h0200, 16'h8000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TARGET, 16'h8000, 16'h7FFF, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_TARGET, 16'h0300, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h01));
      issue_command(make_cmd(scf_pkg::OP_ADD, 16'h7FFF, 16'h7FFF, 8'h00));
   endtask

   // A step with no target must not clamp; a re-clamp must.
   task automatic test_idle_step();
      program_bounds(16'sh0500, 16'sh0500, 16'sh0500, 16'sh0500, 1'b0);
      issue_command(make_cmd(scf_pkg::OP_UNTRACK, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_SET, 16'h7000, 16'h9000, 8'h00));
      program_bounds(16'sh0500, 16'sh0500, 16'sh0500, 16'sh0500, 1'b1);
      issue_command(make_cmd(scf_pkg::OP_STEP, 16'h0000, 16'h0000, 8'h00));
      issue_command(make_cmd(scf_pkg::OP_RECLAMP, 16'h0000, 16'h0000, 8'h00));
   endtask

   // Mostly target-then-step runs with random content, the rest arbitrary commands.
   task automatic run_command_mix(input int count);
      int sent;
      int steps;
      int i;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 6) begin
            if ($urandom_range(0, 1) == 0) begin
               issue_command(make_cmd(scf_pkg::OP_TARGET, view_x + pick_offset(),
                                      view_y + pick_offset(), pick_shift()));
            end else begin
               issue_command(make_cmd(scf_pkg::OP_TARGET, pick_word(), pick_word(),
                                      pick_shift()));
            end
            steps = $urandom_range(1, 20);
            for (i = 0; i < steps; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  issue_command(make_cmd(scf_pkg::op_type'(3'($urandom)), pick_word(),
                                         pick_word(), pick_shift()));
               end else begin
                  issue_command(make_cmd(scf_pkg::OP_STEP, pick_word(), pick_word(),
                                         pick_shift()));
               end
            end
            sent += steps + 1;
         end else begin
            issue_command(make_cmd(scf_pkg::op_type'(3'($urandom)), pick_word(), pick_word(),
                                   pick_shift()));
            sent++;
         end
      end
   endtask

   task automatic test_random_follow();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_bounds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              1'b0);
            1: program_bounds(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
            2: program_bounds(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
            3: program_bounds(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1);
            4: program_bounds(16'shF000, 16'shF800, 16'sh1000, 16'sh0800, 1'b1);
            default: program_bounds(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 1'($urandom));
         endcase
         run_command_mix(245);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      scf_pkg::rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (views_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, rsp_data);
         end else begin
            due = views_due.pop_front();
            compare_field("pos_x", due.pos_x, rsp_data.pos_x);
            compare_field("pos_y", due.pos_y, rsp_data.pos_y);
            compare_field("scroll_x", 16'(due.scroll_x), 16'(rsp_data.scroll_x));
            compare_field("scroll_y", 16'(due.scroll_y), 16'(rsp_data.scroll_y));
            compare_field("conv_x", due.conv_x, rsp_data.conv_x);
            compare_field("conv_y", due.conv_y, rsp_data.conv_y);
            compare_field("following", 16'(due.following), 16'(rsp_data.following));
         end
      end
      // switch between free flow, light, heavy and long-block stalling
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(16, 160);
      end
      stall_span--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0) begin
               stall_hold = !stall_hold;
               stall_run = $urandom_range(1, 12);
            end
            stall_run--;
            rsp_stall <= stall_hold;
         end
      endcase
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("scroll_camera_follow_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_wrap_and_convert();
      test_bound_corners();
      test_idle_step();
      test_random_follow();
      settle_outputs();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("scroll_camera_follow_unit regression: pass");
      end else begin
         $display("scroll_camera_follow_unit regression: fail");
      end
      $finish;
   end

endmodule
